>>> design/psm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types and constants for the PCM stream mixer: transaction payloads,
// operation codes, sequencer states and saturation bounds.
// ----------------------------------------------------------------------------
package psm_pkg;

  // fixed field widths
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned SAMPLE_W = 16;

  // saturation bounds
  localparam logic signed [SAMPLE_W-1:0] SAT_HIGH = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_LOW  = 16'sh8000;

  // operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_PLAY  = 2'd1,
    OP_MIX   = 2'd2
  } op_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // input transaction payload
  typedef struct packed {
    logic [1:0]                 operation;
    logic [2:0]                 channel_sel;
    logic [9:0]                 sample_index;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [LEN_W-1:0]           play_length;
    logic                       loop_flag;
  } in_item_t;

  // result transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       frame_last;
    logic                       play_accepted;
    logic [2:0]                 free_channel;
    logic                       none_free;
  } out_item_t;

  // accumulator control
  typedef struct packed {
    logic clr;
    logic add;
  } acc_ctrl_t;

endpackage : psm_pkg
`default_nettype wire

>>> design/psm_sample_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psm_sample_mem
// Sample store for all channels: one write port, one registered read port.
// ----------------------------------------------------------------------------
module psm_sample_mem
  import psm_pkg::*;
#(
  parameter int unsigned ADDR_W = 13
) (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [ADDR_W-1:0]          wr_addr,
  input  wire logic signed [SAMPLE_W-1:0] wr_data,
  input  wire logic [ADDR_W-1:0]          rd_addr,
  output logic signed [SAMPLE_W-1:0]      rd_data
);

  logic signed [SAMPLE_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule : psm_sample_mem
`default_nettype wire

>>> design/psm_sat_accum.sv
`default_nettype none
// ----------------------------------------------------------------------------
// psm_sat_accum
// Shared saturating accumulator: adds one sample per cycle while add is set
// and clamps the running sum to the signed 16-bit range after each addition.
// ----------------------------------------------------------------------------
module psm_sat_accum
  import psm_pkg::*;
(
  input  wire logic                       clk,
  input  wire acc_ctrl_t                  ctrl,
  input  wire logic signed [SAMPLE_W-1:0] sample,
  output logic signed [SAMPLE_W-1:0]      acc
);

  logic signed [SAMPLE_W-1:0] acc_r;
  logic signed [SAMPLE_W-1:0] acc_nxt;
  logic signed [SAMPLE_W:0]   sum;

  // add and clamp
  always_comb begin
    sum = {acc_r[SAMPLE_W-1], acc_r} + {sample[SAMPLE_W-1], sample};
    priority if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
      acc_nxt = sum[SAMPLE_W] ? SAT_LOW : SAT_HIGH;
    end else begin
      acc_nxt = sum[SAMPLE_W-1:0];
    end
  end

  // running sum
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc_r <= '0;
    end else if (ctrl.add) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule : psm_sat_accum
`default_nettype wire

>>> design/pcm_stream_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pcm_stream_mixer
// Multichannel saturating 16-bit PCM mixer with per-channel stream slots.
// ----------------------------------------------------------------------------
// One transaction in, one transaction out, one at a time. A sample write, a
// play start or an unused operation goes from the idle state straight to the
// completion state; a mix tick passes through the mix and drain states first.
// In the mix state the sequencer visits one channel per cycle through the
// single read port of the sample memory and feeds a single saturating
// accumulator. The sample memory is not cleared after reset:
// reading a store entry that was never written returns an arbitrary sample.
// The input is stalled while a transaction is in work and while a finished
// result waits on a stalled output.
module pcm_stream_mixer
  import psm_pkg::*;
#(
  parameter int unsigned CHANNELS    = 8,
  parameter int unsigned MAX_SAMPLES = 1024
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input channel
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  // result channel
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data,
  // configuration
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned ADDR_W = CH_W + IDX_W;
  localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);

  // sequencer and control
  state_t                state_r, state_nxt;
  logic [CH_W-1:0]       ch_r;
  logic [1:0]            op_r;
  logic                  play_ok_r;
  logic                  add_r;
  logic [15:0]           frame_count_r;
  logic [15:0]           frame_samples_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  // stream slots
  logic [CHANNELS-1:0]   active_r;
  logic [CHANNELS-1:0]   loop_r;
  logic [LEN_W-1:0]      len_r [CHANNELS];
  logic [LEN_W-1:0]      pos_r [CHANNELS];

  // combinational
  logic                  accept;
  logic [CHANNELS-1:0]   free_vec;
  logic [CHANNELS-1:0]   free_onehot;
  logic                  any_free;
  logic                  play_ok;
  logic [LEN_W-1:0]      plen_sat;
  logic [2:0]            free_idx;
  logic                  cur_act;
  logic                  cur_wrap;
  logic                  cur_drop;
  logic                  contrib;
  logic [LEN_W-1:0]      rd_pos;
  logic [31:0]           rd_pos_ext;
  logic [31:0]           wr_ch_ext;
  logic [31:0]           wr_idx_ext;
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] acc;
  acc_ctrl_t             acc_ctrl;
  logic                  frame_end;

  // handshake
  assign in_stall  = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // lowest free slot
  assign free_vec    = ~active_r;
  assign free_onehot = free_vec & (~free_vec + CHANNELS'(1));
  assign any_free    = |free_vec;

  always_comb begin
    free_idx = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_idx = 3'(i);
      end
    end
  end

  // play start checks
  assign plen_sat = (32'(in_data.play_length) > MAX_SAMPLES) ? LEN_W'(MAX_SAMPLES)
                                                             : in_data.play_length;
  assign play_ok  = (in_data.operation == OP_PLAY) && (in_data.play_length != '0)
                    && any_free;

  // sample write port
  assign wr_ch_ext  = 32'(in_data.channel_sel);
  assign wr_idx_ext = 32'(in_data.sample_index);
  assign wr_en      = accept && (in_data.operation == OP_WRITE)
                      && (wr_ch_ext < CHANNELS) && (wr_idx_ext < MAX_SAMPLES);
  assign wr_addr    = {wr_ch_ext[CH_W-1:0], wr_idx_ext[IDX_W-1:0]};

  // frame end test
  assign frame_end = ({1'b0, frame_count_r} + 17'd1) >= {1'b0, frame_samples_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.operation == OP_MIX) ? ST_MIX : ST_DONE;
        end
      end
      ST_MIX: begin
        if (ch_r == CH_LAST) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // per-channel step decisions and unit controls
  always_comb begin
    cur_act    = active_r[ch_r];
    cur_wrap   = pos_r[ch_r] >= len_r[ch_r];
    cur_drop   = cur_act && cur_wrap && !loop_r[ch_r];
    contrib    = (state_r == ST_MIX) && cur_act && !cur_drop;
    rd_pos     = cur_wrap ? '0 : pos_r[ch_r];
    rd_pos_ext = 32'(rd_pos);
    rd_addr    = {ch_r, rd_pos_ext[IDX_W-1:0]};
    acc_ctrl.clr = accept && (in_data.operation == OP_MIX);
    acc_ctrl.add = add_r;
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ch_r      <= '0;
      op_r      <= '0;
      play_ok_r <= 1'b0;
      add_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      add_r   <= contrib;
      if (accept) begin
        ch_r      <= '0;
        op_r      <= in_data.operation;
        play_ok_r <= play_ok;
      end else if (state_r == ST_MIX) begin
        ch_r <= ch_r + CH_W'(1);
      end
    end
  end

  // stream slot state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      loop_r   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        len_r[i] <= '0;
        pos_r[i] <= '0;
      end
    end else if (accept && play_ok) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (free_onehot[i]) begin
          active_r[i] <= 1'b1;
          loop_r[i]   <= in_data.loop_flag;
          len_r[i]    <= plen_sat;
          pos_r[i]    <= '0;
        end
      end
    end else if ((state_r == ST_MIX) && cur_act) begin
      if (cur_drop) begin
        active_r[ch_r] <= 1'b0;
        len_r[ch_r]    <= '0;
        pos_r[ch_r]    <= '0;
      end else begin
        pos_r[ch_r] <= rd_pos + LEN_W'(1);
      end
    end
  end

  // configuration and frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_samples_r <= 16'd256;
      frame_count_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        frame_samples_r <= cfg_wr_data;
      end
      if ((state_r == ST_DONE) && (op_r == OP_MIX)) begin
        frame_count_r <= frame_end ? '0 : frame_count_r + 16'd1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_data_r.mixed_sample  <= (op_r == OP_MIX) ? acc : '0;
      out_data_r.frame_last    <= (op_r == OP_MIX) && frame_end;
      out_data_r.play_accepted <= play_ok_r;
      out_data_r.free_channel  <= free_idx;
      out_data_r.none_free     <= !any_free;
    end
  end

  // sample store
  psm_sample_mem #(
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_data.sample_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // shared saturating adder
  psm_sat_accum u_acc (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .sample (rd_data),
    .acc    (acc)
  );

`ifndef SYNTHESIS
  // a result appears only after the completion state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside completion state");

  // with every slot busy the free channel reads zero
  a_none_free_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.none_free) |-> (out_data_r.free_channel == 3'd0))
    else $error("free channel nonzero while none free");

  // a play result never carries a mix frame flag or sample
  a_play_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.play_accepted) |->
      (!out_data_r.frame_last && (out_data_r.mixed_sample == '0)))
    else $error("play result carries mix fields");

  // the channel counter stays within the slot range while mixing
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX) |-> (32'(ch_r) < CHANNELS))
    else $error("channel counter out of range");
`endif

endmodule : pcm_stream_mixer
`default_nettype wire

>>> tb/pcm_stream_mixer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcm_stream_mixer_tb
// Self-checking bench for the PCM stream mixer. Sample writes, play starts,
// mix ticks and spare operations are queued with their predicted result from
// a shadow copy of the slot state, driven under random valid/stall gaps, and
// every result transaction is compared field by field. The frame length is
// changed between phases while the mixer is idle.
// ----------------------------------------------------------------------------
module pcm_stream_mixer_tb;
  import psm_pkg::*;

  localparam int unsigned NUM_SLOTS   = 8;
  localparam int unsigned SLOT_DEPTH  = 1024;
  localparam int unsigned MAX_LEN     = 1024;
  localparam int unsigned RESET_FRAME = 256;
  localparam int unsigned LOOP_CAP    = 4;
  localparam int unsigned LIMIT_NS    = 1_500_000;
  localparam logic [1:0]  OP_SPARE    = 2'd3;

  logic      clk;
  logic      rst_n       = 1'b0;
  logic      in_valid    = 1'b0;
  logic      in_stall;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_stall   = 1'b0;
  out_item_t out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  pcm_stream_mixer u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // shadow of the mixer state
  logic signed [15:0] pcm_mem     [NUM_SLOTS][SLOT_DEPTH];
  bit                 pcm_written [NUM_SLOTS][SLOT_DEPTH];
  logic [LEN_W-1:0]   slot_len    [NUM_SLOTS];
  logic [LEN_W-1:0]   slot_pos    [NUM_SLOTS];
  bit                 slot_loop   [NUM_SLOTS];
  bit                 slot_on     [NUM_SLOTS];
  logic [15:0]        tick_count;
  logic [15:0]        frame_len;

  // commands waiting to be driven, results predicted for them, and results
  // owed for commands the mixer has taken
  in_item_t  queued_cmds[$];
  out_item_t foreseen_results[$];
  out_item_t awaited_results[$];

  int unsigned mismatches;
  int unsigned results_seen;
  bit          in_fire;
  bit          quiet_tail;
  int unsigned send_gap;
  int unsigned stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(string what, longint got, longint want_v);
    mismatches++;
    $display("mismatch at %0t, result %0d: %s got %0d want %0d",
             $realtime, results_seen, what, got, want_v);
  endtask

  function automatic int lowest_idle_slot();
    for (int c = 0; c < NUM_SLOTS; c++)
      if (!slot_on[c]) return c;
    return -1;
  endfunction

  // one command applied to the shadow state, giving its result
  function automatic out_item_t predict_mixer_step(in_item_t cmd);
    out_item_t res;
    int        acc;
    int        slot;
    res = '0;
    acc = 0;
    if (cmd.operation == OP_WRITE) begin
      pcm_mem[cmd.channel_sel][cmd.sample_index]     = cmd.sample_value;
      pcm_written[cmd.channel_sel][cmd.sample_index] = 1'b1;
    end else if (cmd.operation == OP_PLAY) begin
      slot = lowest_idle_slot();
      if (cmd.play_length != '0 && slot >= 0) begin
        slot_len[slot]    = (cmd.play_length > MAX_LEN) ? LEN_W'(MAX_LEN) : cmd.play_length;
        slot_pos[slot]    = '0;
        slot_loop[slot]   = cmd.loop_flag;
        slot_on[slot]     = 1'b1;
        res.play_accepted = 1'b1;
      end
    end else if (cmd.operation == OP_MIX) begin
      // walk slots in order, clamp after every addition
      for (int c = 0; c < NUM_SLOTS; c++) begin
        if (!slot_on[c]) continue;
        if (slot_pos[c] >= slot_len[c]) begin
          if (slot_loop[c]) begin
            slot_pos[c] = '0;
          end else begin
            slot_on[c]  = 1'b0;
            slot_len[c] = '0;
            slot_pos[c] = '0;
            continue;
          end
        end
        acc += pcm_mem[c][slot_pos[c]];
        if (acc > SAT_HIGH) acc = SAT_HIGH;
        if (acc < SAT_LOW) acc = SAT_LOW;
        slot_pos[c] = slot_pos[c] + 1'b1;
      end
      res.mixed_sample = acc[15:0];
      // frame boundary
      if (int'(tick_count) + 1 >= int'(frame_len)) begin
        res.frame_last = 1'b1;
        tick_count     = '0;
      end else begin
        tick_count = tick_count + 1'b1;
      end
    end
    slot = lowest_idle_slot();
    res.none_free    = (slot < 0);
    res.free_channel = (slot < 0) ? 3'd0 : slot[2:0];
    return res;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(16'h6000, 16'h7FFF));
      3: return 16'($urandom_range(16'h8000, 16'hA000));
      default: return 16'($urandom);
    endcase
  endfunction

  // command with random content in the fields its operation ignores
  function automatic in_item_t noise_item(logic [1:0] op);
    in_item_t it;
    it.operation    = op;
    it.channel_sel  = 3'($urandom_range(0, 7));
    it.sample_index = 10'($urandom_range(0, 1023));
    it.sample_value = pick_sample();
    it.play_length  = 11'($urandom_range(0, 2047));
    it.loop_flag    = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic void queue_cmd(in_item_t it);
    foreseen_results.push_back(predict_mixer_step(it));
    queued_cmds.push_back(it);
  endfunction

  function automatic void queue_write(logic [2:0] ch, logic [9:0] idx, logic [15:0] val);
    in_item_t it;
    it              = noise_item(OP_WRITE);
    it.channel_sel  = ch;
    it.sample_index = idx;
    it.sample_value = val;
    queue_cmd(it);
  endfunction

  function automatic void queue_play(logic [10:0] len, logic lp);
    in_item_t it;
    it             = noise_item(OP_PLAY);
    it.play_length = len;
    it.loop_flag   = lp;
    queue_cmd(it);
  endfunction

  // mix tick; any store entry the tick will read gets written first
  function automatic void queue_mix();
    int idx;
    for (int c = 0; c < NUM_SLOTS; c++) begin
      if (!slot_on[c]) continue;
      idx = -1;
      if (slot_pos[c] < slot_len[c]) idx = slot_pos[c];
      else if (slot_loop[c]) idx = 0;
      if (idx >= 0 && !pcm_written[c][idx])
        queue_write(3'(c), 10'(idx), pick_sample());
    end
    queue_cmd(noise_item(OP_MIX));
  endfunction

  function automatic void queue_random_cmds(int count);
    int          sel;
    int          loops;
    logic [10:0] len;
    logic [2:0]  ch;
    logic [9:0]  idx;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        queue_mix();
      end else if (sel < 65) begin
        // play start, lengths mostly short so streams come and go
        sel = $urandom_range(0, 99);
        if (sel < 55) len = 11'($urandom_range(1, 16));
        else if (sel < 80) len = 11'($urandom_range(17, 200));
        else if (sel < 92) len = 11'($urandom_range(201, 1023));
        else if (sel < 95) len = 11'd1024;
        else if (sel < 98) len = 11'($urandom_range(1025, 2047));
        else len = 11'd0;
        // looping streams never end, so keep them few
        loops = 0;
        for (int c = 0; c < NUM_SLOTS; c++)
          if (slot_on[c] && slot_loop[c]) loops++;
        queue_play(len, loops < LOOP_CAP && $urandom_range(0, 3) == 0);
      end else if (sel < 95) begin
        ch = 3'($urandom_range(0, 7));
        if (slot_on[ch] && $urandom_range(0, 1) == 1)
          idx = 10'(slot_pos[ch] + $urandom_range(0, 7));
        else
          idx = 10'($urandom_range(0, 1023));
        queue_write(ch, idx, pick_sample());
      end else begin
        queue_cmd(noise_item(OP_SPARE));
      end
    end
  endfunction

  // wait until every command is taken and every result is back
  task automatic drain(int settle);
    while (queued_cmds.size() != 0 || foreseen_results.size() != 0 ||
           awaited_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_frame_len(logic [15:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    frame_len   = v;
  endtask

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap = 0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 15) == 0) begin
        send_gap = $urandom_range(0, 11);
        in_valid <= 1'b0;
      end else if (queued_cmds.size() != 0) begin
        in_data  <= queued_cmds.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result stall bursts
  always @(negedge clk) begin
    if (!rst_n || quiet_tail) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // monitor: check results, then log accepted commands
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          report_mismatch("result with no transaction pending", out_data, 0);
        end else begin
          want = awaited_results.pop_front();
          if (out_data.mixed_sample !== want.mixed_sample)
            report_mismatch("mixed_sample", out_data.mixed_sample, want.mixed_sample);
          if (out_data.frame_last !== want.frame_last)
            report_mismatch("frame_last", out_data.frame_last, want.frame_last);
          if (out_data.play_accepted !== want.play_accepted)
            report_mismatch("play_accepted", out_data.play_accepted, want.play_accepted);
          if (out_data.free_channel !== want.free_channel)
            report_mismatch("free_channel", out_data.free_channel, want.free_channel);
          if (out_data.none_free !== want.none_free)
            report_mismatch("none_free", out_data.none_free, want.none_free);
        end
      end
      in_fire = in_valid && !in_stall;
      if (in_fire && foreseen_results.size() != 0)
        awaited_results.push_back(foreseen_results.pop_front());
    end
  end

  // stimulus
  initial begin : stimulus
    for (int c = 0; c < NUM_SLOTS; c++) begin
      slot_len[c]  = '0;
      slot_pos[c]  = '0;
      slot_loop[c] = 1'b0;
      slot_on[c]   = 1'b0;
    end
    tick_count = '0;
    frame_len  = 16'(RESET_FRAME);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: idle mix, spare op, zero-length play, extreme samples
    queue_mix();
    queue_cmd(noise_item(OP_SPARE));
    queue_play(11'd0, 1'b1);
    queue_write(3'd0, 10'd0, 16'h7FFF);
    queue_write(3'd7, 10'd1023, 16'h8000);
    // fill every slot: over-long, full-length, short, looping
    queue_play(11'd2047, 1'b0);
    queue_play(11'd1024, 1'b0);
    queue_play(11'd1, 1'b0);
    queue_play(11'd2, 1'b1);
    queue_play(11'd3, 1'b0);
    queue_play(11'd1, 1'b1);
    queue_play(11'd16, 1'b0);
    queue_play(11'd5, 1'b0);
    // all slots busy
    queue_play(11'd7, 1'b0);
    repeat (6) queue_mix();
    drain(4);

    // random phases across frame lengths
    write_frame_len(16'hFFFF);
    queue_random_cmds(25);
    drain(4);
    write_frame_len(16'h0000);
    queue_random_cmds(20);
    drain(4);
    write_frame_len(16'd1);
    queue_random_cmds(20);
    drain(4);
    write_frame_len(16'd40);
    queue_random_cmds(25);
    // make sure the count sits past the shorter frame that follows
    while (tick_count < 16'd4) queue_mix();
    drain(4);
    write_frame_len(16'd3);
    queue_random_cmds(30);
    drain(4);

    // mostly-mix tail without gaps
    quiet_tail = 1'b1;
    for (int n = 0; n < 45; n++) begin
      if ($urandom_range(0, 9) == 0) queue_random_cmds(1);
      else queue_mix();
    end
    drain(16);

    if (mismatches == 0)
      $display("** pcm_stream_mixer: PASSED **");
    else
      $display("** pcm_stream_mixer: FAILED **");
    $finish;
  end

  // run limit
  initial begin : watchdog
    #(LIMIT_NS);
    $display("** pcm_stream_mixer: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
design/psm_pkg.sv
design/psm_sample_mem.sv
design/psm_sat_accum.sv
design/pcm_stream_mixer.sv
tb/pcm_stream_mixer_tb.sv
